/* rtl/multi_timer_expiry_manager_assert.svh */
// Assertion macros shared by the timer table checkers.
// Depends on nothing; included by the checker file.
`ifndef MULTI_TIMER_EXPIRY_MANAGER_ASSERT_SVH
`define MULTI_TIMER_EXPIRY_MANAGER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MTEM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");

// next-cycle implication, disabled in reset
`define MTEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

/* rtl/mtem_pkg.sv */
// Shared constants and types for the timer table.
// No dependencies; used by the top level and the checker.
package mtem_pkg;

  localparam int IDX_PORT_W = 4;
  localparam int PERIOD_W   = 32;
  localparam int RES_LIMIT  = 16;
  localparam int RES_CNT_W  = 5;

  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_CREATE = 3'd1;
  localparam logic [2:0] FN_START  = 3'd2;
  localparam logic [2:0] FN_STOP   = 3'd3;
  localparam logic [2:0] FN_CHG    = 3'd4;
  localparam logic [2:0] FN_DELETE = 3'd5;
  localparam logic [2:0] FN_QUERY  = 3'd6;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [IDX_PORT_W-1:0] idx;
    logic                  active;
    logic                  last;
  } res_t;

endpackage

/* rtl/mtem_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
// No dependencies; holds expiry ticks and periods for the timer table.
module mtem_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/multi_timer_expiry_manager.sv */
// Timer table: NUM_TIMERS timers driven by create/start/stop/change/delete/query
// commands and a tick beat. Expiry ticks and periods sit in two RAMs with
// registered reads, active and reload flags in flops. Create, stop, delete,
// change period and an unused code finish on acceptance; start reads the period,
// then writes the expiry; a query registers its answer, then waits for the output
// register. During a tick the sweep reads one timer entry per cycle from the
// RAMs and writes back rearmed expiries, and it pauses while an expiry report
// waits on out_tready. Reports of one tick come in index order, at most 16,
// the final one with out_tlast set. Depends on mtem_pkg and mtem_ram.
module multi_timer_expiry_manager #(
  parameter int NUM_TIMERS = 16,
  parameter int TICK_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // timer_index[3:0], period[35:4], auto_reload[36], zeros
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // timer_index_res[3:0], active[4], zeros
  output logic        out_tuser,  // kind
  output logic        out_tlast
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_QRY   = 3'd2;
  localparam logic [2:0] ST_TICK  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // input fields
  logic [mtem_pkg::IDX_PORT_W-1:0] in_idx;
  logic [mtem_pkg::PERIOD_W-1:0]   in_period;
  logic                            in_reload;
  logic [mtem_pkg::PERIOD_W-1:0]   per_clamp;
  logic [IDX_W-1:0]                in_ent;
  logic                            in_ok;
  logic                            in_acc;

  assign in_idx    = in_tdata[3:0];
  assign in_period = in_tdata[35:4];
  assign in_reload = in_tdata[36];
  assign per_clamp = (in_period == '0) ? mtem_pkg::PERIOD_W'(1) : in_period;
  assign in_ent    = IDX_W'(in_idx);
  assign in_ok     = 32'(in_idx) < NUM_TIMERS;

  // state
  logic [2:0]                 state_r, state_nxt;
  logic [TICK_BITS-1:0]       now_r, now_nxt;
  logic [NUM_TIMERS-1:0]      active_r, active_nxt;
  logic [NUM_TIMERS-1:0]      reload_r, reload_nxt;
  logic [IDX_W-1:0]           cmd_ent_r, cmd_ent_nxt;
  logic [CNT_W-1:0]           rd_cnt_r, rd_cnt_nxt;
  logic                       v2_r, v2_nxt;
  logic [IDX_W-1:0]           idx2_r, idx2_nxt;
  logic [mtem_pkg::RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                       pend_v_r, pend_v_nxt;
  mtem_pkg::res_t             pend_r, pend_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mtem_pkg::res_t             out_r, out_nxt;

  // RAM ports
  logic                       exp_we, per_we, rd_en;
  logic [IDX_W-1:0]           exp_waddr, per_waddr, raddr;
  logic [TICK_BITS-1:0]       exp_wdata, exp_rd;
  logic [mtem_pkg::PERIOD_W-1:0] per_wdata, per_rd;

  mtem_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TICK_BITS)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (exp_rd)
  );

  mtem_ram #(.DEPTH(NUM_TIMERS), .WIDTH(mtem_pkg::PERIOD_W)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (per_rd)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    logic out_free;
    logic hit;
    logic take;
    logic stall;
    logic adv;
    logic issue;

    state_nxt     = state_r;
    now_nxt       = now_r;
    active_nxt    = active_r;
    reload_nxt    = reload_r;
    cmd_ent_nxt   = cmd_ent_r;
    rd_cnt_nxt    = rd_cnt_r;
    v2_nxt        = v2_r;
    idx2_nxt      = idx2_r;
    res_cnt_nxt   = res_cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    exp_we        = 1'b0;
    exp_waddr     = in_ent;
    exp_wdata     = now_r + TICK_BITS'(per_clamp);
    per_we        = 1'b0;
    per_waddr     = in_ent;
    per_wdata     = per_clamp;
    rd_en         = 1'b0;
    raddr         = in_ent;

    out_free      = !out_valid_r || out_tready;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    hit   = v2_r && active_r[idx2_r] && (exp_rd == now_r);
    take  = hit && (res_cnt_r < mtem_pkg::RES_CNT_W'(mtem_pkg::RES_LIMIT));
    stall = take && pend_v_r && !out_free;
    adv   = !stall;
    issue = adv && (32'(rd_cnt_r) < NUM_TIMERS);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            mtem_pkg::FN_TICK: begin
              now_nxt     = now_r + TICK_BITS'(1);
              rd_cnt_nxt  = '0;
              v2_nxt      = 1'b0;
              res_cnt_nxt = '0;
              pend_v_nxt  = 1'b0;
              state_nxt   = ST_TICK;
            end
            mtem_pkg::FN_CREATE: begin
              if (in_ok) begin
                per_we             = 1'b1;
                reload_nxt[in_ent] = in_reload;
                active_nxt[in_ent] = 1'b0;
              end
            end
            mtem_pkg::FN_START: begin
              if (in_ok) begin
                rd_en       = 1'b1;
                cmd_ent_nxt = in_ent;
                state_nxt   = ST_START;
              end
            end
            mtem_pkg::FN_STOP, mtem_pkg::FN_DELETE: begin
              if (in_ok) begin
                active_nxt[in_ent] = 1'b0;
              end
            end
            mtem_pkg::FN_CHG: begin
              if (in_ok) begin
                per_we             = 1'b1;
                exp_we             = 1'b1;
                active_nxt[in_ent] = 1'b1;
              end
            end
            mtem_pkg::FN_QUERY: begin
              pend_nxt.kind   = mtem_pkg::KIND_QUERY;
              pend_nxt.idx    = in_idx;
              pend_nxt.active = in_ok && active_r[in_ent];
              pend_nxt.last   = 1'b1;
              state_nxt       = ST_QRY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_START: begin
        exp_we                = 1'b1;
        exp_waddr             = cmd_ent_r;
        exp_wdata             = now_r + TICK_BITS'(per_rd);
        active_nxt[cmd_ent_r] = 1'b1;
        state_nxt             = ST_IDLE;
      end
      ST_QRY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_TICK: begin
        raddr = IDX_W'(rd_cnt_r);
        rd_en = issue;
        if (adv) begin
          if (hit) begin
            if (reload_r[idx2_r]) begin
              exp_we    = 1'b1;
              exp_waddr = idx2_r;
              exp_wdata = exp_rd + TICK_BITS'(per_rd);
            end else begin
              active_nxt[idx2_r] = 1'b0;
            end
          end
          if (take) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_v_nxt      = 1'b1;
            pend_nxt.kind   = mtem_pkg::KIND_EXPIRY;
            pend_nxt.idx    = mtem_pkg::IDX_PORT_W'(idx2_r);
            pend_nxt.active = reload_r[idx2_r];
            pend_nxt.last   = 1'b0;
            res_cnt_nxt     = res_cnt_r + mtem_pkg::RES_CNT_W'(1);
          end
          v2_nxt   = issue;
          idx2_nxt = IDX_W'(rd_cnt_r);
          if (issue) begin
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end
        end
        if (!v2_r && 32'(rd_cnt_r) == NUM_TIMERS) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // flush the held report with the last flag
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      active_r    <= '0;
      reload_r    <= '0;
      rd_cnt_r    <= '0;
      v2_r        <= 1'b0;
      res_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      active_r    <= active_nxt;
      reload_r    <= reload_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      v2_r        <= v2_nxt;
      res_cnt_r   <= res_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_ent_r <= cmd_ent_nxt;
    idx2_r    <= idx2_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.active, out_r.idx};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

/* rtl/mtem_checker.sv */
// Port-level checks for the timer table, bound to the top level.
// Depends on mtem_pkg and multi_timer_expiry_manager_assert.svh.
`include "multi_timer_expiry_manager_assert.svh"

module mtem_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  logic       in_beat;
  logic       busy_cmd;
  logic       out_stall;
  logic       out_query;
  logic [9:0] out_word;

  assign in_beat   = in_tvalid && in_tready;
  assign busy_cmd  = (in_tuser == mtem_pkg::FN_TICK) || (in_tuser == mtem_pkg::FN_QUERY);
  assign out_stall = out_tvalid && !out_tready;
  assign out_query = out_tvalid && (out_tuser == mtem_pkg::KIND_QUERY);
  assign out_word  = {out_tlast, out_tuser, out_tdata};

  // a stalled result beat holds
  `MTEM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_word))
  // a query answer is always the only beat of its command
  `MTEM_ASSERT_NOW(a_query_last, clk, rst_n, out_query, out_tlast)
  // ticks and queries keep the input closed for at least the next cycle
  `MTEM_ASSERT_NEXT(a_busy_after, clk, rst_n, in_beat && busy_cmd, !in_tready)
  // padding bits of the result stay zero
  `MTEM_ASSERT_NOW(a_out_pad, clk, rst_n, out_tvalid, out_tdata[7:5] == 3'b000)

endmodule

bind multi_timer_expiry_manager mtem_checker u_mtem_checker (.*);
